@@ hdl/csm_pkg.sv @@
// Shared types, codes and arithmetic helpers of the chassis speed command mixer.
`default_nettype none
package csm_pkg;

    typedef logic signed [44:0] t_wide;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_DIV_GO,
        S_DIV_WAIT,
        S_CMD,
        S_LK0,
        S_LK1,
        S_LK2,
        S_ROT,
        S_ROUND,
        S_FOL0,
        S_FOL1,
        S_DONE
    } t_state;

    localparam logic [1:0] CTRL_STICK = 2'd0;
    localparam logic [1:0] CTRL_KEY   = 2'd1;

    localparam logic [2:0] MOVE_PLAIN = 3'd0;
    localparam logic [2:0] MOVE_GYRO  = 3'd1;
    localparam logic [2:0] MOVE_SPIN  = 3'd2;
    localparam logic [2:0] MOVE_LOB   = 3'd3;

    localparam logic [2:0] REG_MAX_SPEED   = 3'd0;
    localparam logic [2:0] REG_STICK_FULL  = 3'd1;
    localparam logic [2:0] REG_KEY_FWD     = 3'd2;
    localparam logic [2:0] REG_KEY_BACK    = 3'd3;
    localparam logic [2:0] REG_KEY_RIGHT   = 3'd4;
    localparam logic [2:0] REG_KEY_LEFT    = 3'd5;
    localparam logic [2:0] REG_FOLLOW_GAIN = 3'd6;
    localparam logic [2:0] REG_SPIN_SPEED  = 3'd7;

    localparam t_wide FRONT_MAX = 45'sd8388607;
    localparam t_wide FRONT_MIN = -45'sd8388608;
    localparam t_wide TURN_MAX  = 45'sd16777215;
    localparam t_wide TURN_MIN  = -45'sd16777216;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [11:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;

    // Quarter-wave sine entry in Q15, built from a fixed-point Taylor series.
    function automatic logic [15:0] sine_entry(input int k, input int bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          q;
        x    = (64'd1686628288 * 64'(k)) >> bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        q = (sum + 64'sd16384) >>> 15;
        if (q > 32768) begin
            q = 32768;
        end
        return q[15:0];
    endfunction

    // Shift right by k with rounding to nearest, ties away from zero.
    function automatic t_wide round_shift(input t_wide v, input int k);
        t_wide mag;
        t_wide q;
        mag = (v < 0) ? -v : v;
        q   = (mag + (t_wide'(1) <<< (k - 1))) >>> k;
        return (v < 0) ? -q : q;
    endfunction

    function automatic logic signed [23:0] sat_front(input t_wide v);
        t_wide r;
        r = (v > FRONT_MAX) ? FRONT_MAX : ((v < FRONT_MIN) ? FRONT_MIN : v);
        return r[23:0];
    endfunction

    function automatic logic signed [24:0] sat_turn(input t_wide v);
        t_wide r;
        r = (v > TURN_MAX) ? TURN_MAX : ((v < TURN_MIN) ? TURN_MIN : v);
        return r[24:0];
    endfunction

endpackage
`default_nettype wire

@@ hdl/chassis_speed_command_mixer_unit.sv @@
// Chassis speed command mixer: turns one control tick of operator commands into speed targets.
// Each word is worked by a small sequencer around one shared multiplier and a bit-serial
// divider. A stick word runs three scaled terms through the divider, a key word four;
// the gyro and spin modes add the table reads, the four rotation products and the follow
// term, which spin mode replaces by its set spin speed. Offline, lob and unknown move
// modes go straight to the done state. The input is ready only while the sequencer is idle;
// a finished word waits in the output register while the next one runs.
`default_nettype none
module chassis_speed_command_mixer_unit
    import csm_pkg::*;
#(
    parameter int ANGLE_TABLE_BITS = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_addr,
    input  wire logic [15:0]        i_cfg_wdata,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_link_online,
    input  wire logic [1:0]         i_ctrl_mode,
    input  wire logic [2:0]         i_move_mode,
    input  wire logic signed [10:0] i_stick_front,
    input  wire logic signed [10:0] i_stick_right,
    input  wire logic signed [10:0] i_stick_turn,
    input  wire logic [11:0]        i_key_forward,
    input  wire logic [11:0]        i_key_back,
    input  wire logic [11:0]        i_key_right,
    input  wire logic [11:0]        i_key_left,
    input  wire logic signed [15:0] i_mouse_dx,
    input  wire logic signed [15:0] i_yaw_angle,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [23:0]      o_front_speed,
    output logic signed [23:0]      o_right_speed,
    output logic signed [24:0]      o_turn_speed,
    output logic                    o_position_control
);

    localparam int B = ANGLE_TABLE_BITS;

    logic [14:0]        r_max_speed;
    logic [10:0]        r_stick_full;
    logic [11:0]        r_key_full [4];
    logic [7:0]         r_follow_gain;
    logic signed [15:0] r_spin_speed;

    logic               r_online;
    logic [1:0]         r_ctrl;
    logic [2:0]         r_move;
    logic signed [10:0] r_stick [3];
    logic [11:0]        r_key [4];
    logic signed [15:0] r_mouse;
    logic signed [15:0] r_yaw;

    t_state             r_state;
    t_state             n_state;
    logic [1:0]         r_idx;
    logic signed [44:0] r_prod;
    logic signed [32:0] r_term [4];
    logic signed [42:0] r_acc0;
    logic signed [42:0] r_acc1;
    logic signed [16:0] r_sin;
    logic signed [16:0] r_cos;
    logic signed [23:0] r_f;
    logic signed [23:0] r_r;
    logic signed [24:0] r_t;
    logic               r_pm;

    logic signed [23:0] r_held_f;
    logic signed [23:0] r_held_r;
    logic signed [24:0] r_held_t;
    logic               r_held_pm;

    logic               r_out_valid;
    logic signed [23:0] r_out_f;
    logic signed [23:0] r_out_r;
    logic signed [24:0] r_out_t;
    logic               r_out_pm;

    logic signed [24:0] w_mul_a;
    logic signed [19:0] w_mul_b;
    logic signed [44:0] w_mul_p;
    t_div_req           w_div_req;
    t_div_rsp           w_div_rsp;
    logic [B:0]         w_rom_addr;
    logic [15:0]        w_rom_data;

    logic [16:0]        w_ayaw;
    logic [12:0]        w_a;
    logic               w_big;
    logic [11:0]        w_su;
    logic [11:0]        w_cu;
    logic [11+B:0]      w_sidx_full;
    logic [11+B:0]      w_cidx_full;
    logic               w_fe_neg;
    logic signed [12:0] w_fe;
    logic [1:0]         w_last;
    logic signed [12:0] w_scale_op;
    logic [11:0]        w_den;
    logic [31:0]        w_mag;
    logic signed [23:0] w_cmd_f;
    logic signed [23:0] w_cmd_r;
    logic signed [24:0] w_cmd_t;
    logic               w_flip;
    logic               w_fire;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed   <= 15'd8000;
            r_stick_full  <= 11'd660;
            r_key_full[0] <= 12'd1000;
            r_key_full[1] <= 12'd1000;
            r_key_full[2] <= 12'd1000;
            r_key_full[3] <= 12'd1000;
            r_follow_gain <= 8'd30;
            r_spin_speed  <= 16'sd500;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_MAX_SPEED:   r_max_speed   <= i_cfg_wdata[14:0];
                REG_STICK_FULL:  r_stick_full  <= i_cfg_wdata[10:0];
                REG_KEY_FWD:     r_key_full[0] <= i_cfg_wdata[11:0];
                REG_KEY_BACK:    r_key_full[1] <= i_cfg_wdata[11:0];
                REG_KEY_RIGHT:   r_key_full[2] <= i_cfg_wdata[11:0];
                REG_KEY_LEFT:    r_key_full[3] <= i_cfg_wdata[11:0];
                REG_FOLLOW_GAIN: r_follow_gain <= i_cfg_wdata[7:0];
                REG_SPIN_SPEED:  r_spin_speed  <= i_cfg_wdata;
                default:         r_spin_speed  <= r_spin_speed;
            endcase
        end
    end

    // Angle decomposition of the latched yaw.
    assign w_ayaw      = r_yaw[15] ? -{r_yaw[15], r_yaw} : {r_yaw[15], r_yaw};
    assign w_a         = w_ayaw[15:3];
    assign w_big       = w_a > 13'd2048;
    assign w_su        = w_big ? 12'(13'd4096 - w_a) : w_a[11:0];
    assign w_cu        = w_big ? 12'(w_a - 13'd2048) : 12'(13'd2048 - w_a);
    assign w_sidx_full = ((12 + B)'(w_su) << B) + (12 + B)'(1024);
    assign w_cidx_full = ((12 + B)'(w_cu) << B) + (12 + B)'(1024);
    assign w_fe_neg    = r_yaw[15] ^ w_big;
    assign w_fe        = w_fe_neg ? -$signed({1'b0, w_su}) : $signed({1'b0, w_su});
    assign w_flip      = w_ayaw > 17'd16384;

    assign w_last = (r_ctrl == CTRL_STICK) ? 2'd2 : 2'd3;

    always_comb begin
        w_scale_op = '0;
        w_den      = 12'd1;
        if (r_ctrl == CTRL_STICK) begin
            case (r_idx)
                2'd0:    w_scale_op = 13'(r_stick[0]);
                2'd1:    w_scale_op = 13'(r_stick[1]);
                default: w_scale_op = 13'(r_stick[2]);
            endcase
            w_den = (r_stick_full == '0) ? 12'd1 : {1'b0, r_stick_full};
        end else begin
            w_scale_op = $signed({1'b0, r_key[r_idx]});
            w_den      = (r_key_full[r_idx] == '0) ? 12'd1 : r_key_full[r_idx];
        end
    end

    assign w_mag = r_prod[44] ? 32'(-r_prod) : r_prod[31:0];

    // New command from the scaled terms, before any rotation.
    always_comb begin
        w_cmd_f = r_f;
        w_cmd_r = r_r;
        w_cmd_t = r_t;
        case (r_ctrl)
            CTRL_STICK: begin
                w_cmd_f = sat_front(t_wide'(r_term[0]));
                w_cmd_r = sat_front(t_wide'(r_term[1]));
                w_cmd_t = sat_turn(t_wide'(r_term[2]));
            end
            CTRL_KEY: begin
                w_cmd_f = sat_front(t_wide'(r_term[0]) - t_wide'(r_term[1]));
                w_cmd_r = sat_front(t_wide'(r_term[2]) - t_wide'(r_term[3]));
                w_cmd_t = sat_turn((t_wide'(r_mouse) <<< 8) + (t_wide'(r_mouse) <<< 5));
            end
            default: begin
                w_cmd_f = r_f;
            end
        endcase
        if (r_move == MOVE_PLAIN && w_flip) begin
            w_cmd_f = sat_front(-t_wide'(w_cmd_f));
            w_cmd_r = sat_front(-t_wide'(w_cmd_r));
        end
    end

    assign w_fire = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!r_online) begin
                    n_state = S_DONE;
                end else if (r_move == MOVE_PLAIN || r_move == MOVE_GYRO
                             || r_move == MOVE_SPIN) begin
                    n_state = (r_ctrl == CTRL_STICK || r_ctrl == CTRL_KEY) ? S_MUL : S_CMD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MUL:      n_state = S_DIV_GO;
            S_DIV_GO:   n_state = S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (w_div_rsp.done) begin
                    n_state = (r_idx == w_last) ? S_CMD : S_MUL;
                end
            end
            S_CMD:      n_state = (r_move == MOVE_PLAIN) ? S_DONE : S_LK0;
            S_LK0:      n_state = S_LK1;
            S_LK1:      n_state = S_LK2;
            S_LK2:      n_state = S_ROT;
            S_ROT:      n_state = (r_idx == 2'd3) ? S_ROUND : S_ROT;
            S_ROUND:    n_state = S_FOL0;
            S_FOL0:     n_state = S_FOL1;
            S_FOL1:     n_state = S_DONE;
            S_DONE: begin
                if (w_fire) begin
                    n_state = S_IDLE;
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        w_mul_a            = '0;
        w_mul_b            = '0;
        w_rom_addr         = w_sidx_full[11+B:11];
        w_div_req.start    = 1'b0;
        w_div_req.dividend = w_mag + 32'(w_den >> 1);
        w_div_req.divisor  = w_den;
        case (r_state)
            S_MUL: begin
                w_mul_a = 25'(w_scale_op);
                w_mul_b = $signed({1'b0, r_max_speed, 4'b0});
            end
            S_DIV_GO: begin
                w_div_req.start = 1'b1;
            end
            S_LK1: begin
                w_rom_addr = w_cidx_full[11+B:11];
            end
            S_ROT: begin
                w_mul_a = (r_idx == 2'd0 || r_idx == 2'd3) ? 25'(r_f) : 25'(r_r);
                w_mul_b = (r_idx == 2'd0 || r_idx == 2'd2) ? 20'(r_cos) : 20'(r_sin);
            end
            S_FOL0: begin
                w_mul_a = 25'(w_fe);
                w_mul_b = $signed({7'b0, w_su[11:0], 1'b0}) >>> 1;
            end
            S_FOL1: begin
                w_mul_a = r_prod[24:0];
                w_mul_b = $signed({12'b0, r_follow_gain});
            end
            default: begin
                w_mul_a = '0;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_held_f    <= '0;
            r_held_r    <= '0;
            r_held_t    <= '0;
            r_held_pm   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_held_f    <= r_f;
                r_held_r    <= r_r;
                r_held_t    <= r_t;
                r_held_pm   <= r_pm;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_f  <= r_f;
            r_out_r  <= r_r;
            r_out_t  <= r_t;
            r_out_pm <= r_pm;
        end
        case (r_state)
            S_IDLE: begin
                r_online   <= i_link_online;
                r_ctrl     <= i_ctrl_mode;
                r_move     <= i_move_mode;
                r_stick[0] <= i_stick_front;
                r_stick[1] <= i_stick_right;
                r_stick[2] <= i_stick_turn;
                r_key[0]   <= i_key_forward;
                r_key[1]   <= i_key_back;
                r_key[2]   <= i_key_right;
                r_key[3]   <= i_key_left;
                r_mouse    <= i_mouse_dx;
                r_yaw      <= i_yaw_angle;
            end
            S_DECODE: begin
                r_idx <= '0;
                r_pm  <= (r_online && r_move == MOVE_LOB) ? 1'b1 : r_held_pm;
                if (r_online) begin
                    r_f <= r_held_f;
                    r_r <= r_held_r;
                    r_t <= r_held_t;
                end else begin
                    r_f <= '0;
                    r_r <= '0;
                    r_t <= '0;
                end
            end
            S_MUL: begin
                r_prod <= w_mul_p;
            end
            S_DIV_WAIT: begin
                if (w_div_rsp.done) begin
                    r_term[r_idx] <= r_prod[44] ? -$signed({1'b0, w_div_rsp.quotient})
                                                :  $signed({1'b0, w_div_rsp.quotient});
                    r_idx <= r_idx + 2'd1;
                end
            end
            S_CMD: begin
                r_f   <= w_cmd_f;
                r_r   <= w_cmd_r;
                r_t   <= w_cmd_t;
                r_idx <= '0;
            end
            S_LK1: begin
                r_sin <= r_yaw[15] ? -$signed({1'b0, w_rom_data}) : $signed({1'b0, w_rom_data});
            end
            S_LK2: begin
                r_cos <= w_big ? -$signed({1'b0, w_rom_data}) : $signed({1'b0, w_rom_data});
            end
            S_ROT: begin
                r_idx <= r_idx + 2'd1;
                case (r_idx)
                    2'd0:    r_acc0 <= 43'(w_mul_p);
                    2'd1:    r_acc0 <= r_acc0 - 43'(w_mul_p);
                    2'd2:    r_acc1 <= 43'(w_mul_p);
                    default: r_acc1 <= r_acc1 + 43'(w_mul_p);
                endcase
            end
            S_ROUND: begin
                r_f <= sat_front(round_shift(t_wide'(r_acc0), 15));
                r_r <= sat_front(round_shift(t_wide'(r_acc1), 15));
            end
            S_FOL0: begin
                r_prod <= w_mul_p;
            end
            S_FOL1: begin
                r_pm <= 1'b0;
                if (r_move == MOVE_SPIN) begin
                    r_t <= {{5{r_spin_speed[15]}}, r_spin_speed, 4'b0};
                end else begin
                    r_t <= sat_turn(round_shift(w_mul_p, 8));
                end
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
    end

    csm_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    csm_sine_rom #(
        .TABLE_BITS (B)
    ) u_sine_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_rom_data)
    );

    assign o_in_ready         = (r_state == S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_front_speed      = r_out_f;
    assign o_right_speed      = r_out_r;
    assign o_turn_speed       = r_out_t;
    assign o_position_control = r_out_pm;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DECODE))
        else $error("accepted word did not start the sequencer");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV_WAIT))
        else $error("divider finished outside its wait state");

    a_offline_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_online) |-> (r_f == '0 && r_r == '0 && r_t == '0))
        else $error("offline word carries nonzero speed");

endmodule
`default_nettype wire

@@ hdl/csm_divider.sv @@
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module csm_divider
    import csm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [11:0] r_rem;
    logic [11:0] r_den;
    logic [31:0] r_quo;
    logic [12:0] w_shift;
    logic        w_ge;
    logic [12:0] w_diff;

    assign w_shift = {r_rem, r_quo[31]};
    assign w_ge    = w_shift >= {1'b0, r_den};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[11:0] : w_shift[11:0];
            r_quo <= {r_quo[30:0], w_ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule
`default_nettype wire

@@ hdl/csm_sine_rom.sv @@
// Quarter-wave sine table with registered read.
`default_nettype none
module csm_sine_rom
    import csm_pkg::*;
#(
    parameter int TABLE_BITS = 10
) (
    input  wire logic                  i_clk,
    input  wire logic [TABLE_BITS:0]   i_addr,
    output logic      [15:0]           o_data
);

    localparam int DEPTH = (1 << TABLE_BITS) + 1;

    logic [15:0] w_table [DEPTH];
    logic [15:0] r_data;

    for (genvar g = 0; g < DEPTH; g++) begin : g_entry
        assign w_table[g] = sine_entry(g, TABLE_BITS);
    end

    always_ff @(posedge i_clk) begin
        r_data <= w_table[i_addr];
    end

    assign o_data = r_data;

endmodule
`default_nettype wire
